/* hw/rtl/dksl_pkg.sv */
// Shared types and constants of the date-keyed sorted list.
package dksl_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MONTH = 3'd1,
		ST_BAD_DAY   = 3'd2,
		ST_FULL      = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	localparam logic [2:0]  REG_CAPACITY = 3'd0;
	localparam logic [4:0]  CAP_RESET    = 5'd16;
	localparam logic [3:0]  MONTHS       = 4'd12;

	// Modular inverse of 25 mod 2^16 and the largest product of a multiple of 25.
	localparam logic [15:0] INV25        = 16'd23593;
	localparam logic [15:0] DIV25_MAX    = 16'd2621;

	// Ordering key: year, month, day, then identifier, highest bits first.
	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [63:0] id;
	} entry_t;

	typedef struct packed {
		logic wr;
		logic occ;
		logic tail;
	} cell_ctl_t;

	typedef struct packed {
		logic [1:0]  pad;
		logic [4:0]  read_index;
		logic [15:0] in_year;
		logic [3:0]  in_month;
		logic [4:0]  in_day;
		logic [63:0] key_id;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  pad;
		logic [4:0]  entry_count;
		logic [15:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [63:0] out_id;
		status_t     status;
	} out_item_t;

endpackage

/* hw/rtl/dksl_cell.sv */
// One storage cell of the sorted chain: holds an entry and shifts or loads on insert.
module dksl_cell (
	input  logic               clk,
	input  dksl_pkg::entry_t    new_ent,
	input  dksl_pkg::entry_t    left_ent,
	input  logic               left_gt,
	input  dksl_pkg::cell_ctl_t ctl,
	output logic               gt,
	output dksl_pkg::entry_t    ent
);
	import dksl_pkg::*;

	entry_t ent_q;

	assign gt  = ctl.occ && (new_ent < ent_q);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (ctl.wr && (gt || ctl.tail)) begin
			ent_q <= left_gt ? left_ent : new_ent;
		end
	end

endmodule

/* hw/rtl/dksl_date_check.sv */
// Gregorian date validation: month range, then day against month length.
module dksl_date_check (
	input  logic [4:0]         day,
	input  logic [3:0]         month,
	input  logic [15:0]        year,
	output dksl_pkg::status_t   status
);
	import dksl_pkg::*;

	logic [15:0] prod;
	logic        div25;
	logic        leap;
	logic [4:0]  mlen;

	assign prod  = year * INV25;
	assign div25 = prod <= DIV25_MAX;
	assign leap  = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));

	always_comb begin
		unique case (month) inside
			4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
			4'd2:                    mlen = leap ? 5'd29 : 5'd28;
			default:                 mlen = 5'd31;
		endcase
	end

	always_comb begin
		if (month == 4'd0 || month > MONTHS) begin
			status = ST_BAD_MONTH;
		end else if (day == 5'd0 || day > mlen) begin
			status = ST_BAD_DAY;
		end else begin
			status = ST_OK;
		end
	end

endmodule

/* hw/rtl/date_keyed_sorted_list.sv */
// Top level of the date-keyed sorted list: stream ports, APB register, cell chain.
// Keeps up to DEPTH entries ordered by date then identifier in a chain of
// compare-and-shift cells. Every cell compares the incoming entry with its own
// and takes either its left neighbor's entry or the new one, so an insert
// completes in parallel across the chain; a read selects one cell. One
// transaction is accepted per cycle while s_tready is high, and its result
// is registered into the output register; input is taken while a result
// waits as long as the output register is freed in the same cycle. The
// stores need no clearing after reset: only positions below the count are
// ever read. Capacity (address 0) caps the entry count, saturated to DEPTH.
module date_keyed_sorted_list #(
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  dksl_pkg::in_item_t    s_tdata,  // key_id, in_day, in_month, in_year, read_index
	input  logic                 s_tuser,  // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output dksl_pkg::out_item_t   m_tdata,  // status, out_id, out_day, out_month, out_year,
	                                       // entry_count
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import dksl_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > 5) ? CW : 5;

	logic [4:0]    cap_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_next;
	logic          out_valid_q;
	out_item_t     out_data_q;
	out_item_t     res;

	logic          accept;
	logic          ins_ok;
	status_t       date_st;
	entry_t        new_ent;
	entry_t        rd_ent;
	entry_t        ent [DEPTH];
	logic          gt  [DEPTH];
	logic [LW-1:0] cnt_ext;
	logic [LW-1:0] cnt_next_ext;
	logic [LW-1:0] ridx_ext;
	logic [LW-1:0] limit;

	assign pready   = 1'b1;
	assign prdata   = (paddr == REG_CAPACITY) ? {27'd0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_CAPACITY) begin
			cap_q <= pwdata[4:0];
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign new_ent.year  = s_tdata.in_year;
	assign new_ent.month = s_tdata.in_month;
	assign new_ent.day   = s_tdata.in_day;
	assign new_ent.id    = s_tdata.key_id;

	dksl_date_check u_date (
		.day    (s_tdata.in_day),
		.month  (s_tdata.in_month),
		.year   (s_tdata.in_year),
		.status (date_st)
	);

	assign cnt_ext  = LW'(cnt_q);
	assign ridx_ext = LW'(s_tdata.read_index);
	assign limit    = (LW'(cap_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_q);
	assign ins_ok   = (cmd_t'(s_tuser) == CMD_INSERT) && (date_st == ST_OK)
		&& (cnt_ext < limit);

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.wr   = accept && ins_ok;
		assign ctl.occ  = LW'(g) < cnt_ext;
		assign ctl.tail = LW'(g) == cnt_ext;
		if (g == 0) begin : g_head
			dksl_cell u_cell (
				.clk      (clk),
				.new_ent  (new_ent),
				.left_ent (new_ent),
				.left_gt  (1'b0),
				.ctl      (ctl),
				.gt       (gt[g]),
				.ent      (ent[g])
			);
		end else begin : g_body
			dksl_cell u_cell (
				.clk      (clk),
				.new_ent  (new_ent),
				.left_ent (ent[g-1]),
				.left_gt  (gt[g-1]),
				.ctl      (ctl),
				.gt       (gt[g]),
				.ent      (ent[g])
			);
		end
	end

	always_comb begin
		rd_ent = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (ridx_ext == LW'(i)) begin
				rd_ent = rd_ent | ent[i];
			end
		end
	end

	assign cnt_next     = ins_ok ? cnt_q + CW'(1) : cnt_q;
	assign cnt_next_ext = LW'(cnt_next);

	always_comb begin
		res             = '0;
		res.entry_count = cnt_next_ext[4:0];
		if (cmd_t'(s_tuser) == CMD_INSERT) begin
			if (date_st != ST_OK) begin
				res.status = date_st;
			end else if (!ins_ok) begin
				res.status = ST_FULL;
			end else begin
				res.status = ST_OK;
			end
		end else if (ridx_ext >= cnt_ext) begin
			res.status = ST_RANGE;
		end else begin
			res.status    = ST_OK;
			res.out_id    = rd_ent.id;
			res.out_day   = rd_ent.day;
			res.out_month = rd_ent.month;
			res.out_year  = rd_ent.year;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= res;
		end
	end

endmodule

/* hw/rtl/dksl_checker.sv */
// Port-level assertions for the date-keyed sorted list, bound to the top level.
module dksl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input dksl_pkg::out_item_t m_tdata
);
	import dksl_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted transaction produced no result");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata.status != ST_OK |->
			m_tdata.out_id == 64'd0 && m_tdata.out_day == 5'd0
			&& m_tdata.out_month == 4'd0 && m_tdata.out_year == 16'd0)
		else $error("refused transaction carries entry data");

endmodule

bind date_keyed_sorted_list dksl_checker u_dksl_checker (.*);
